### rtl/class_file_structure_parser_macros.svh
// Assertion macros shared by the parser checker.
`ifndef CLASS_FILE_STRUCTURE_PARSER_MACROS_SVH
`define CLASS_FILE_STRUCTURE_PARSER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CFSP_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// Next-cycle implication checked outside reset.
`define CFSP_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

### rtl/cfsp_pkg.sv
// ----------------------------------------------------------------------------
// cfsp_pkg: shared types and constants of the class file parser
// Payload structs, phase codes, status codes and field length tables.
// ----------------------------------------------------------------------------
package cfsp_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic [4:0]  field_kind;
      logic [63:0] field_value;
      logic [15:0] table_index;
      logic [1:0]  status;
   } rsp_type;

   localparam logic [4:0] PH_MAGIC   = 5'd0;
   localparam logic [4:0] PH_CPCOUNT = 5'd3;
   localparam logic [4:0] PH_CPTAG   = 5'd4;
   localparam logic [4:0] PH_CPBODY  = 5'd5;
   localparam logic [4:0] PH_UTFLEN  = 5'd6;
   localparam logic [4:0] PH_UTFBYTE = 5'd7;
   localparam logic [4:0] PH_ACCESS  = 5'd8;
   localparam logic [4:0] PH_IFCOUNT = 5'd11;
   localparam logic [4:0] PH_IFENTRY = 5'd12;
   localparam logic [4:0] PH_FCOUNT  = 5'd13;
   localparam logic [4:0] PH_FACC    = 5'd14;
   localparam logic [4:0] PH_FACOUNT = 5'd17;
   localparam logic [4:0] PH_ANAME   = 5'd18;
   localparam logic [4:0] PH_ALEN    = 5'd19;
   localparam logic [4:0] PH_ABYTE   = 5'd20;
   localparam logic [4:0] PH_MCOUNT  = 5'd21;
   localparam logic [4:0] PH_MACC    = 5'd22;
   localparam logic [4:0] PH_MACOUNT = 5'd25;
   localparam logic [4:0] PH_CACOUNT = 5'd26;
   localparam logic [4:0] PH_DONE    = 5'd27;

   localparam logic [1:0] OWNER_FIELD  = 2'd1;
   localparam logic [1:0] OWNER_METHOD = 2'd2;
   localparam logic [1:0] OWNER_CLASS  = 2'd3;

   localparam logic [1:0] ST_FIELD = 2'd0;
   localparam logic [1:0] ST_DONE  = 2'd1;
   localparam logic [1:0] ST_TRUNC = 2'd2;
   localparam logic [1:0] ST_BADTAG = 2'd3;

   localparam logic [4:0] TAG_UTF8   = 5'd1;
   localparam logic [4:0] TAG_LONG   = 5'd5;
   localparam logic [4:0] TAG_DOUBLE = 5'd6;

   // Phases at or beyond the done phase take single bytes.
   function automatic logic [3:0] phase_len(input logic [4:0] ph);
      unique case (ph)
         PH_MAGIC, PH_ALEN:                          phase_len = 4'd4;
         PH_CPTAG, PH_CPBODY, PH_UTFBYTE, PH_ABYTE:  phase_len = 4'd1;
         default: phase_len = (ph >= PH_DONE) ? 4'd1 : 4'd2;
      endcase
   endfunction

   // Body length of a constant pool entry; zero marks an unknown tag.
   function automatic logic [3:0] body_len(input logic [7:0] tag);
      unique case (tag)
         8'd1, 8'd7, 8'd8, 8'd16, 8'd19, 8'd20: body_len = 4'd2;
         8'd3, 8'd4, 8'd9, 8'd10, 8'd11, 8'd12, 8'd17, 8'd18: body_len = 4'd4;
         8'd5, 8'd6: body_len = 4'd8;
         8'd15:      body_len = 4'd3;
         default:    body_len = 4'd0;
      endcase
   endfunction

endpackage

### rtl/class_file_structure_parser.sv
// ----------------------------------------------------------------------------
// class_file_structure_parser: streaming class file structure parser
// Consumes a class file one item per byte and emits one item per field.
// ----------------------------------------------------------------------------
// The request channel (req_valid, req_ready, req_data) carries one byte of the
// class file per item, with end_of_file set on the last byte. The response
// channel (rsp_valid, rsp_ready, rsp_data) carries the completed fields: kind,
// big-endian value, table index and status. Utf8 and attribute body bytes come
// out one item each. A byte that only extends a multi-byte field makes no item.
// A byte accepted at one edge has its result item registered at that edge and shown on
// rsp_data after it. Throughput is one byte per cycle while req_ready is high, set by
// the single registered parse step that updates the phase, counters and accumulator.
// The output register refills in the same cycle it drains, so req_ready is low
// only while a result item waits and the receiver holds rsp_ready low.
// Reset is synchronous and returns the parser to the magic phase with an empty
// output register. After a completion, truncation or unknown tag report, all
// further bytes are accepted and dropped until reset.
// ----------------------------------------------------------------------------
module class_file_structure_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cfsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cfsp_pkg::rsp_type rsp_data
);

   logic [4:0]  phase_ff, phase_in;
   logic [2:0]  bif_ff, bif_in;
   logic [55:0] acc_ff, acc_in;
   logic [4:0]  tag_ff, tag_in;
   logic [15:0] slot_ff, slot_in;
   logic [15:0] size_ff, size_in;
   logic [15:0] ent_ff, ent_in;
   logic [15:0] attr_ff, attr_in;
   logic [31:0] pay_ff, pay_in;
   logic        fin_ff, fin_in;
   logic        vld_ff;
   cfsp_pkg::rsp_type out_ff, out_in;
   logic        emit;

   assign req_ready = !vld_ff || rsp_ready;
   assign rsp_valid = vld_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      logic [7:0]  b;
      logic [63:0] acc;
      logic [3:0]  len;
      logic [15:0] idx, v16, ent_dec, attr_dec;
      logic [1:0]  st;
      logic        do_emit, pool_next, end_mem, end_attr, start_attr;
      logic [16:0] nxt;
      logic [1:0]  owner;
      b = req_data.data_byte;
      acc = {acc_ff, b};
      v16 = acc[15:0];
      len = cfsp_pkg::phase_len(phase_ff);
      idx = '0;
      st = cfsp_pkg::ST_FIELD;
      pool_next = 1'b0;
      end_mem = 1'b0;
      end_attr = 1'b0;
      start_attr = 1'b0;
      nxt = '0;
      owner = tag_ff[1:0];
      ent_dec = ent_ff - 16'd1;
      attr_dec = attr_ff - 16'd1;
      phase_in = phase_ff; bif_in = bif_ff; acc_in = acc_ff; tag_in = tag_ff;
      slot_in = slot_ff; size_in = size_ff; ent_in = ent_ff; attr_in = attr_ff;
      pay_in = pay_ff; fin_in = fin_ff;
      if (phase_ff == cfsp_pkg::PH_CPBODY) begin
         len = cfsp_pkg::body_len({3'b000, tag_ff});
         if (len == 4'd0) len = 4'd1;
      end
      if ((phase_ff >= cfsp_pkg::PH_CPTAG && phase_ff <= cfsp_pkg::PH_UTFBYTE) ||
          phase_ff == cfsp_pkg::PH_IFENTRY ||
          (phase_ff >= cfsp_pkg::PH_FACC && phase_ff <= cfsp_pkg::PH_FACOUNT) ||
          (phase_ff >= cfsp_pkg::PH_MACC && phase_ff <= cfsp_pkg::PH_MACOUNT))
         idx = slot_ff;
      else if (phase_ff >= cfsp_pkg::PH_ANAME && phase_ff <= cfsp_pkg::PH_ABYTE)
         idx = size_ff - attr_ff;
      do_emit = ({1'b0, bif_ff} + 4'd1) >= len;
      if (!do_emit) begin
         bif_in = bif_ff + 3'd1;
         acc_in = acc[55:0];
      end else begin
         bif_in = '0;
         acc_in = '0;
         unique case (phase_ff)
            cfsp_pkg::PH_CPCOUNT: begin
               size_in = v16;
               slot_in = 16'd1;
               phase_in = (v16 <= 16'd1) ? cfsp_pkg::PH_ACCESS : cfsp_pkg::PH_CPTAG;
            end
            cfsp_pkg::PH_CPTAG: begin
               if (b == {3'b000, cfsp_pkg::TAG_UTF8}) begin
                  tag_in = cfsp_pkg::TAG_UTF8;
                  phase_in = cfsp_pkg::PH_UTFLEN;
               end else if (cfsp_pkg::body_len(b) != 4'd0) begin
                  tag_in = b[4:0];
                  phase_in = cfsp_pkg::PH_CPBODY;
               end else begin
                  st = cfsp_pkg::ST_BADTAG;
               end
            end
            cfsp_pkg::PH_CPBODY: pool_next = 1'b1;
            cfsp_pkg::PH_UTFLEN: begin
               pay_in = {16'd0, v16};
               if (v16 == 16'd0) pool_next = 1'b1;
               else phase_in = cfsp_pkg::PH_UTFBYTE;
            end
            cfsp_pkg::PH_UTFBYTE: begin
               pay_in = pay_ff - 32'd1;
               if (pay_ff == 32'd1) pool_next = 1'b1;
            end
            cfsp_pkg::PH_IFCOUNT: begin
               ent_in = v16;
               slot_in = '0;
               phase_in = (v16 != 16'd0) ? cfsp_pkg::PH_IFENTRY : cfsp_pkg::PH_FCOUNT;
            end
            cfsp_pkg::PH_IFENTRY: begin
               ent_in = ent_dec;
               slot_in = slot_ff + 16'd1;
               if (ent_dec == 16'd0) phase_in = cfsp_pkg::PH_FCOUNT;
            end
            cfsp_pkg::PH_FCOUNT: begin
               tag_in = {3'b000, cfsp_pkg::OWNER_FIELD};
               ent_in = v16;
               slot_in = '0;
               phase_in = (v16 != 16'd0) ? cfsp_pkg::PH_FACC : cfsp_pkg::PH_MCOUNT;
            end
            cfsp_pkg::PH_MCOUNT: begin
               tag_in = {3'b000, cfsp_pkg::OWNER_METHOD};
               ent_in = v16;
               slot_in = '0;
               phase_in = (v16 != 16'd0) ? cfsp_pkg::PH_MACC : cfsp_pkg::PH_CACOUNT;
            end
            cfsp_pkg::PH_FACOUNT: begin
               start_attr = 1'b1; owner = cfsp_pkg::OWNER_FIELD;
            end
            cfsp_pkg::PH_MACOUNT: begin
               start_attr = 1'b1; owner = cfsp_pkg::OWNER_METHOD;
            end
            cfsp_pkg::PH_CACOUNT: begin
               start_attr = 1'b1; owner = cfsp_pkg::OWNER_CLASS;
            end
            cfsp_pkg::PH_ANAME: phase_in = cfsp_pkg::PH_ALEN;
            cfsp_pkg::PH_ALEN: begin
               pay_in = acc[31:0];
               if (acc[31:0] == 32'd0) end_attr = 1'b1;
               else phase_in = cfsp_pkg::PH_ABYTE;
            end
            cfsp_pkg::PH_ABYTE: begin
               pay_in = pay_ff - 32'd1;
               if (pay_ff == 32'd1) end_attr = 1'b1;
            end
            default: phase_in = phase_ff + 5'd1;
         endcase
         // A wide pool entry takes two slots; the pool ends when the next slot
         // reaches or passes the pool count.
         if (pool_next) begin
            nxt = {1'b0, slot_ff} +
                  ((tag_ff == cfsp_pkg::TAG_LONG || tag_ff == cfsp_pkg::TAG_DOUBLE) ?
                   17'd2 : 17'd1);
            if (nxt >= {1'b0, size_ff}) phase_in = cfsp_pkg::PH_ACCESS;
            else begin
               slot_in = nxt[15:0];
               phase_in = cfsp_pkg::PH_CPTAG;
            end
         end
         if (start_attr) begin
            tag_in = {3'b000, owner};
            attr_in = v16;
            size_in = v16;
            if (v16 != 16'd0) phase_in = cfsp_pkg::PH_ANAME;
            else if (owner == cfsp_pkg::OWNER_CLASS) phase_in = cfsp_pkg::PH_DONE;
            else end_mem = 1'b1;
         end
         if (end_attr) begin
            attr_in = attr_dec;
            if (attr_dec != 16'd0) phase_in = cfsp_pkg::PH_ANAME;
            else if (owner == cfsp_pkg::OWNER_CLASS) phase_in = cfsp_pkg::PH_DONE;
            else end_mem = 1'b1;
         end
         if (end_mem) begin
            ent_in = ent_dec;
            slot_in = slot_ff + 16'd1;
            if (owner == cfsp_pkg::OWNER_FIELD)
               phase_in = (ent_dec == 16'd0) ? cfsp_pkg::PH_MCOUNT : cfsp_pkg::PH_FACC;
            else
               phase_in = (ent_dec == 16'd0) ? cfsp_pkg::PH_CACOUNT : cfsp_pkg::PH_MACC;
         end
         if (st == cfsp_pkg::ST_BADTAG) fin_in = 1'b1;
         else if (phase_in == cfsp_pkg::PH_DONE) begin
            st = cfsp_pkg::ST_DONE;
            fin_in = 1'b1;
         end
      end
      if (req_data.end_of_file && st == cfsp_pkg::ST_FIELD) begin
         st = cfsp_pkg::ST_TRUNC;
         do_emit = 1'b1;
         fin_in = 1'b1;
      end
      emit = do_emit && !fin_ff;
      out_in.field_kind  = phase_ff;
      out_in.field_value = acc;
      out_in.table_index = idx;
      out_in.status      = st;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cfsp_pkg::PH_MAGIC;
         bif_ff <= '0; acc_ff <= '0; tag_ff <= '0;
         slot_ff <= 16'd1; size_ff <= '0; ent_ff <= '0; attr_ff <= '0;
         pay_ff <= '0; fin_ff <= 1'b0; vld_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready && !fin_ff) begin
            phase_ff <= phase_in; bif_ff <= bif_in; acc_ff <= acc_in;
            tag_ff <= tag_in; slot_ff <= slot_in; size_ff <= size_in;
            ent_ff <= ent_in; attr_ff <= attr_in; pay_ff <= pay_in;
            fin_ff <= fin_in;
         end
         // A new result item refills the register in the cycle it drains.
         if (req_valid && req_ready && emit) vld_ff <= 1'b1;
         else if (rsp_ready) vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready && emit) out_ff <= out_in;
   end

endmodule

### rtl/cfsp_checker.sv
// ----------------------------------------------------------------------------
// cfsp_checker: port-level checks of the class file parser
// Watches the handshakes and the result items of the top level.
// ----------------------------------------------------------------------------
`include "class_file_structure_parser_macros.svh"
module cfsp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input cfsp_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input cfsp_pkg::rsp_type rsp_data
);
   logic ended_ff;

   // Set once a final status item has been delivered.
   always_ff @(posedge clock) begin
      if (reset) ended_ff <= 1'b0;
      else if (rsp_valid && rsp_ready && rsp_data.status != cfsp_pkg::ST_FIELD)
         ended_ff <= 1'b1;
   end

   `CFSP_ASSERT_IMP(a_ready_when_free, clock, reset, !rsp_valid, req_ready,
      "input stalled with empty output register")
   `CFSP_ASSERT_NEXT(a_hold_stalled, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data), "stalled result item changed")
   `CFSP_ASSERT_IMP(a_silent_after_end, clock, reset, ended_ff, !rsp_valid,
      "result item after the end of the parse")
   `CFSP_ASSERT_NEXT(a_eof_reports, clock, reset,
      req_valid && req_ready && req_data.end_of_file && !ended_ff && !rsp_valid,
      rsp_valid || ended_ff, "end of file gave no report")
endmodule

bind class_file_structure_parser cfsp_checker u_cfsp_checker (.*);

### test/class_file_structure_parser_test.sv
// ----------------------------------------------------------------------------
// class_file_structure_parser_test: self-checking bench of the class file parser
// Streams one class file, directed at its head and random in its body, through
// the parser. A software copy of the parse step predicts every field item, and
// the receiver compares each received item with the oldest prediction.
// ----------------------------------------------------------------------------
module class_file_structure_parser_test;

   // Number of input items sent in a run, trailing ignored bytes included.
   localparam int unsigned ITEM_TOTAL = 800;

   // Clock, reset and the two channels of the parser.
   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   cfsp_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   cfsp_pkg::rsp_type rsp_data;

   class_file_structure_parser i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // Field items that the parser still owes us, oldest first.
   cfsp_pkg::rsp_type expected_fields[$];
   int unsigned error_count = 0;
   int unsigned bytes_sent = 0;

   // How the file ends: 0 complete, 1 cut short by end_of_file, 2 unknown tag.
   int unsigned ending_mode;
   // Bytes left until the truncating end_of_file; zero means no cut.
   int unsigned bytes_to_cut = 0;
   bit          receiver_held = 1'b0;
   int unsigned hold_left = 0;

   // ------------------------------------------------------------------------
   // Predictor state: our own copy of the parser's registers.
   // ------------------------------------------------------------------------
   int unsigned   phase_now;
   int unsigned   byte_count;
   logic [63:0]   partial_value;
   int unsigned   tag_or_owner;
   int unsigned   slot_or_entry;
   int unsigned   pool_or_attr_total;
   int unsigned   members_left;
   int unsigned   attrs_left;
   int unsigned   bytes_left;
   bit            parse_over;

   // Number of bytes that make up a field in each phase.
   function automatic int unsigned field_bytes(input int unsigned ph);
      case (ph)
         cfsp_pkg::PH_MAGIC, cfsp_pkg::PH_ALEN: return 4;
         cfsp_pkg::PH_CPTAG, cfsp_pkg::PH_CPBODY,
         cfsp_pkg::PH_UTFBYTE, cfsp_pkg::PH_ABYTE: return 1;
         default: return (ph >= cfsp_pkg::PH_DONE) ? 1 : 2;
      endcase
   endfunction

   // Body size of a constant pool entry by tag; zero for tags we do not know.
   function automatic int unsigned entry_body_bytes(input int unsigned tag);
      case (tag)
         1, 7, 8, 16, 19, 20:           return 2;
         3, 4, 9, 10, 11, 12, 17, 18:   return 4;
         5, 6:                          return 8;
         15:                            return 3;
         default:                       return 0;
      endcase
   endfunction

   function automatic void advance_pool_slot();
      int unsigned nxt;
      nxt = slot_or_entry + ((tag_or_owner == cfsp_pkg::TAG_LONG ||
                              tag_or_owner == cfsp_pkg::TAG_DOUBLE) ? 2 : 1);
      if (nxt >= pool_or_attr_total) begin
         phase_now = cfsp_pkg::PH_ACCESS;
      end else begin
         slot_or_entry = nxt & 16'hFFFF;
         phase_now = cfsp_pkg::PH_CPTAG;
      end
   endfunction

   function automatic void close_member();
      members_left = (members_left - 1) & 16'hFFFF;
      slot_or_entry = (slot_or_entry + 1) & 16'hFFFF;
      if (tag_or_owner == cfsp_pkg::OWNER_FIELD) begin
         phase_now = (members_left == 0) ? cfsp_pkg::PH_MCOUNT : cfsp_pkg::PH_FACC;
      end else begin
         phase_now = (members_left == 0) ? cfsp_pkg::PH_CACOUNT : cfsp_pkg::PH_MACC;
      end
   endfunction

   function automatic void open_attributes(input int unsigned count,
                                           input int unsigned owner);
      tag_or_owner = owner;
      attrs_left = count;
      pool_or_attr_total = count;
      if (count != 0) begin
         phase_now = cfsp_pkg::PH_ANAME;
      end else if (owner == cfsp_pkg::OWNER_CLASS) begin
         phase_now = cfsp_pkg::PH_DONE;
      end else begin
         close_member();
      end
   endfunction

   function automatic void close_attribute();
      attrs_left = (attrs_left - 1) & 16'hFFFF;
      if (attrs_left != 0) begin
         phase_now = cfsp_pkg::PH_ANAME;
      end else if (tag_or_owner == cfsp_pkg::OWNER_CLASS) begin
         phase_now = cfsp_pkg::PH_DONE;
      end else begin
         close_member();
      end
   endfunction

   function automatic void open_members(input int unsigned count, input int unsigned first,
                                        input int unsigned empty);
      members_left = count;
      slot_or_entry = 0;
      phase_now = (count != 0) ? first : empty;
   endfunction

   // One parse step for an accepted byte; queues the field item it causes.
   function automatic void parse_byte(input logic [7:0] b, input logic eof);
      int unsigned ph;
      logic [63:0] acc;
      int unsigned len;
      int unsigned idx;
      int unsigned v16;
      logic [1:0]  st;
      bit          emit;
      cfsp_pkg::rsp_type item;
      if (parse_over) return;
      ph = phase_now & 31;
      acc = {partial_value[55:0], b};
      len = field_bytes(ph);
      idx = 0;
      st = cfsp_pkg::ST_FIELD;
      if (ph == cfsp_pkg::PH_CPBODY) begin
         len = entry_body_bytes(tag_or_owner);
         if (len == 0) len = 1;
      end
      if ((ph >= cfsp_pkg::PH_CPTAG && ph <= cfsp_pkg::PH_UTFBYTE) ||
          ph == cfsp_pkg::PH_IFENTRY ||
          (ph >= cfsp_pkg::PH_FACC && ph <= cfsp_pkg::PH_FACOUNT) ||
          (ph >= cfsp_pkg::PH_MACC && ph <= cfsp_pkg::PH_MACOUNT)) begin
         idx = slot_or_entry;
      end else if (ph >= cfsp_pkg::PH_ANAME && ph <= cfsp_pkg::PH_ABYTE) begin
         idx = (pool_or_attr_total - attrs_left) & 16'hFFFF;
      end
      emit = (byte_count + 1 >= len);
      if (!emit) begin
         byte_count = (byte_count + 1) & 7;
         partial_value = acc;
      end else begin
         v16 = acc[15:0];
         byte_count = 0;
         partial_value = '0;
         case (ph)
            cfsp_pkg::PH_CPCOUNT: begin
               pool_or_attr_total = v16;
               slot_or_entry = 1;
               phase_now = (v16 <= 1) ? cfsp_pkg::PH_ACCESS : cfsp_pkg::PH_CPTAG;
            end
            cfsp_pkg::PH_CPTAG: begin
               if (b == cfsp_pkg::TAG_UTF8) begin
                  tag_or_owner = cfsp_pkg::TAG_UTF8;
                  phase_now = cfsp_pkg::PH_UTFLEN;
               end else if (entry_body_bytes(b) != 0) begin
                  tag_or_owner = b;
                  phase_now = cfsp_pkg::PH_CPBODY;
               end else begin
                  st = cfsp_pkg::ST_BADTAG;
               end
            end
            cfsp_pkg::PH_CPBODY: advance_pool_slot();
            cfsp_pkg::PH_UTFLEN: begin
               bytes_left = v16;
               if (v16 == 0) advance_pool_slot();
               else phase_now = cfsp_pkg::PH_UTFBYTE;
            end
            cfsp_pkg::PH_UTFBYTE: begin
               bytes_left = bytes_left - 1;
               if (bytes_left == 0) advance_pool_slot();
            end
            cfsp_pkg::PH_IFCOUNT:
               open_members(v16, cfsp_pkg::PH_IFENTRY, cfsp_pkg::PH_FCOUNT);
            cfsp_pkg::PH_IFENTRY: begin
               members_left = (members_left - 1) & 16'hFFFF;
               slot_or_entry = (slot_or_entry + 1) & 16'hFFFF;
               if (members_left == 0) phase_now = cfsp_pkg::PH_FCOUNT;
            end
            cfsp_pkg::PH_FCOUNT: begin
               tag_or_owner = cfsp_pkg::OWNER_FIELD;
               open_members(v16, cfsp_pkg::PH_FACC, cfsp_pkg::PH_MCOUNT);
            end
            cfsp_pkg::PH_FACOUNT: open_attributes(v16, cfsp_pkg::OWNER_FIELD);
            cfsp_pkg::PH_MCOUNT: begin
               tag_or_owner = cfsp_pkg::OWNER_METHOD;
               open_members(v16, cfsp_pkg::PH_MACC, cfsp_pkg::PH_CACOUNT);
            end
            cfsp_pkg::PH_MACOUNT: open_attributes(v16, cfsp_pkg::OWNER_METHOD);
            cfsp_pkg::PH_CACOUNT: open_attributes(v16, cfsp_pkg::OWNER_CLASS);
            cfsp_pkg::PH_ANAME:   phase_now = cfsp_pkg::PH_ALEN;
            cfsp_pkg::PH_ALEN: begin
               bytes_left = acc[31:0];
               if (bytes_left == 0) close_attribute();
               else phase_now = cfsp_pkg::PH_ABYTE;
            end
            cfsp_pkg::PH_ABYTE: begin
               bytes_left = bytes_left - 1;
               if (bytes_left == 0) close_attribute();
            end
            default: phase_now = (ph + 1) & 31;
         endcase
         if (st == cfsp_pkg::ST_BADTAG) begin
            parse_over = 1'b1;
         end else if (phase_now == cfsp_pkg::PH_DONE) begin
            st = cfsp_pkg::ST_DONE;
            parse_over = 1'b1;
         end
      end
      // An end of file that does not finish the parse reports truncation.
      if (eof && st == cfsp_pkg::ST_FIELD) begin
         st = cfsp_pkg::ST_TRUNC;
         emit = 1'b1;
         parse_over = 1'b1;
      end
      if (emit) begin
         item.field_kind  = ph[4:0];
         item.field_value = acc;
         item.table_index = idx[15:0];
         item.status      = st;
         expected_fields.insert(expected_fields.size(), item);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Clock, limit and receiver.
   // ------------------------------------------------------------------------
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("** class_file_structure_parser: FAILED **");
      $finish;
   end

   // Receiver: the idle rate depends on how far the file has gone. Once, early
   // on, it holds off for a long stretch so the parser fills and stalls input.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_fields.size() == 0) begin
            $error("unexpected item kind %0d value %h", rsp_data.field_kind,
                   rsp_data.field_value);
            error_count++;
         end else begin
            if (rsp_data.field_kind !== expected_fields[0].field_kind) begin
               $error("field_kind expected %0d got %0d", expected_fields[0].field_kind,
                      rsp_data.field_kind);
               error_count++;
            end
            if (rsp_data.field_value !== expected_fields[0].field_value) begin
               $error("field_value expected %h got %h", expected_fields[0].field_value,
                      rsp_data.field_value);
               error_count++;
            end
            if (rsp_data.table_index !== expected_fields[0].table_index) begin
               $error("table_index expected %0d got %0d", expected_fields[0].table_index,
                      rsp_data.table_index);
               error_count++;
            end
            if (rsp_data.status !== expected_fields[0].status) begin
               $error("status expected %0d got %0d", expected_fields[0].status,
                      rsp_data.status);
               error_count++;
            end
            void'(expected_fields.pop_front());
         end
      end
      if (!receiver_held && bytes_sent >= 60) begin
         receiver_held <= 1'b1;
         hold_left <= 300;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (bytes_sent < 300) begin
         rsp_ready <= ($urandom_range(0, 99) >= 84);
      end else if (bytes_sent < 600) begin
         rsp_ready <= ($urandom_range(0, 99) >= 24);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Sender side.
   // ------------------------------------------------------------------------

   // Offer one byte, wait until it is taken and predict what it causes.
   task automatic send_byte(input logic [7:0] b);
      int unsigned idle_pct;
      logic eof;
      eof = 1'b0;
      if (bytes_to_cut != 0) begin
         bytes_to_cut--;
         eof = (bytes_to_cut == 0);
      end
      idle_pct = (bytes_sent < 300) ? 24 : (bytes_sent < 600) ? 84 : 0;
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= {b, eof};
      do @(posedge clock); while (!req_ready);
      parse_byte(b, eof);
      bytes_sent++;
   endtask

   task automatic send_u16(input logic [15:0] v);
      send_byte(v[15:8]);
      send_byte(v[7:0]);
   endtask

   task automatic send_u32(input logic [31:0] v);
      send_u16(v[31:16]);
      send_u16(v[15:0]);
   endtask

   // Attribute table: name, length and a short body of random bytes.
   task automatic send_attributes(input int unsigned count);
      int unsigned len;
      send_u16(16'(count));
      for (int unsigned a = 0; a < count; a++) begin
         len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
         send_u16(16'($urandom));
         send_u32(len);
         for (int unsigned k = 0; k < len; k++) send_byte(8'($urandom));
      end
   endtask

   // Magic and versions with extreme values.
   task automatic test_header();
      send_u32(32'hCAFEBABE);
      send_u16(16'h0000);
      send_u16(16'hFFFF);
   endtask

   // Constant pool: a few directed entries first, then random ones. A long
   // pool ending in an unknown tag is used when that ending was chosen; an
   // empty pool is used now and then.
   task automatic test_constant_pool();
      int unsigned count;
      int unsigned slot;
      int unsigned bad_slot;
      int unsigned tag;
      int unsigned len;
      if (ending_mode == 2) count = $urandom_range(50, 70);
      else if ($urandom_range(0, 3) == 0) count = $urandom_range(0, 1);
      else count = $urandom_range(6, 14);
      bad_slot = (ending_mode == 2) ? count - $urandom_range(1, 3) : 0;
      send_u16(16'(count));
      slot = 1;
      while (slot < count) begin
         case (slot)
            1: tag = cfsp_pkg::TAG_UTF8;
            2: tag = cfsp_pkg::TAG_UTF8;
            3: tag = cfsp_pkg::TAG_LONG;
            5: tag = 3;
            6: tag = 4;
            default: begin
               tag = $urandom_range(0, 9) < 4 ? cfsp_pkg::TAG_UTF8 : $urandom_range(3, 20);
               while (entry_body_bytes(tag) == 0) tag = $urandom_range(3, 20);
            end
         endcase
         // The wide entry at the end of the pool is made common.
         if (slot == count - 1 && $urandom_range(0, 1)) tag = cfsp_pkg::TAG_DOUBLE;
         // A wide entry may step over the chosen slot, so the first slot at or
         // past it carries the unknown tag.
         if (ending_mode == 2 && slot >= bad_slot) begin
            case ($urandom_range(0, 3))
               0: tag = 0;
               1: tag = 2;
               2: tag = $urandom_range(13, 14);
               default: tag = $urandom_range(21, 255);
            endcase
            send_byte(8'(tag));
            return;
         end
         send_byte(8'(tag));
         if (tag == cfsp_pkg::TAG_UTF8) begin
            len = (slot == 1) ? 0 : (slot == 2) ? 1 : $urandom_range(0, 20);
            send_u16(16'(len));
            for (int unsigned k = 0; k < len; k++) begin
               send_byte(slot == 2 ? 8'hFF : 8'($urandom));
            end
         end else begin
            len = entry_body_bytes(tag);
            for (int unsigned k = 0; k < len; k++) begin
               send_byte(slot == 5 ? 8'h00 : slot == 6 ? 8'hFF : 8'($urandom));
            end
         end
         slot += (tag == cfsp_pkg::TAG_LONG || tag == cfsp_pkg::TAG_DOUBLE) ? 2 : 1;
      end
   endtask

   // Class flags and the interface table, after a pause that drains the parser.
   task automatic test_interfaces();
      int unsigned count;
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_fields.size() != 0) @(posedge clock);
      send_u16(16'($urandom));
      send_u16(16'($urandom));
      send_u16(16'($urandom));
      count = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 40);
      send_u16(16'(count));
      for (int unsigned k = 0; k < count; k++) send_u16(16'($urandom));
   endtask

   // Fields or methods, each with its own attribute table.
   task automatic test_members();
      int unsigned count;
      count = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      send_u16(16'(count));
      for (int unsigned m = 0; m < count; m++) begin
         send_u16(16'($urandom));
         send_u16(16'($urandom));
         send_u16(16'($urandom));
         send_attributes(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3));
      end
   endtask

   // Class attributes, then bytes after the end, which must be ignored.
   task automatic test_class_tail();
      send_attributes($urandom_range(0, 3));
      for (int unsigned k = 0; k < 6; k++) send_byte(8'($urandom));
      bytes_to_cut = 1;
      send_byte(8'($urandom));
      send_byte(8'($urandom));
      while (bytes_sent < ITEM_TOTAL) send_byte(8'($urandom));
   endtask

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   initial begin
      phase_now = cfsp_pkg::PH_MAGIC;
      byte_count = 0;
      partial_value = '0;
      tag_or_owner = 0;
      slot_or_entry = 1;
      pool_or_attr_total = 0;
      members_left = 0;
      attrs_left = 0;
      bytes_left = 0;
      parse_over = 1'b0;
      ending_mode = $urandom_range(0, 3) == 0 ? 2 : $urandom_range(0, 1);
      if (ending_mode == 1) bytes_to_cut = $urandom_range(20, 300);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_header();
      test_constant_pool();
      test_interfaces();
      test_members();
      test_members();
      test_class_tail();
      req_valid <= 1'b0;
      while (expected_fields.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (error_count == 0 && expected_fields.size() == 0) begin
         $display("** class_file_structure_parser: PASSED **");
      end else begin
         $display("** class_file_structure_parser: FAILED **");
      end
      $finish;
   end

endmodule
